>>> rtl/hmr_pkg.sv
// Shared types and constants for the masked RGB histogram matching block.
`default_nettype none
package hmr_pkg;

  localparam int COUNT_WIDTH = 20;
  localparam int LVL_W       = 8;
  localparam int LEVELS      = 256;
  localparam int CHANNELS    = 3;
  localparam logic [LVL_W-1:0] LEVEL_MAX = 8'd255;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_ACCUM  = 2'd1,
    ACT_BUILD  = 2'd2,
    ACT_REMAP  = 2'd3
  } action_t;

  typedef enum logic [0:0] {
    T_IDLE = 1'b0,
    T_ROUT = 1'b1
  } top_state_t;

  typedef enum logic [2:0] {
    L_IDLE = 3'd0,
    L_CLR  = 3'd1,
    L_ACCW = 3'd2,
    L_BRD  = 3'd3,
    L_BADD = 3'd4
  } lane_state_t;

  typedef struct packed {
    logic             start;
    action_t          action;
    logic [LVL_W-1:0] src_lvl;
    logic [LVL_W-1:0] tgt_lvl;
  } lane_cmd_t;

  typedef struct packed {
    logic             busy;
    logic [LVL_W-1:0] map_q;
  } lane_sts_t;

endpackage
`default_nettype wire

>>> rtl/hmr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module hmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/hmr_lane.sv
// One color channel: level counts, cumulative walk that builds the level map, map lookup.
`default_nettype none
module hmr_lane (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire hmr_pkg::lane_cmd_t cmd,
  output      hmr_pkg::lane_sts_t sts
);
  import hmr_pkg::*;

  lane_state_t state, state_next;

  logic [LVL_W-1:0]       clr_addr;
  logic [LVL_W-1:0]       acc_src, acc_tgt;
  logic [LVL_W-1:0]       wi, wj;
  logic [COUNT_WIDTH-1:0] cs, ct;
  logic                   need_s, need_t;

  logic                   sc_we, tc_we, sc_re, tc_re, mp_we, mp_re;
  logic [LVL_W-1:0]       sc_waddr, tc_waddr, sc_raddr, tc_raddr, mp_waddr, mp_raddr;
  logic [COUNT_WIDTH-1:0] sc_wdata, tc_wdata, sc_q, tc_q;
  logic [LVL_W-1:0]       mp_wdata, mp_q;

  logic [COUNT_WIDTH-1:0] cs_sum, ct_sum;
  logic                   hit;

  assign cs_sum = cs + (need_s ? sc_q : '0);
  assign ct_sum = ct + (need_t ? tc_q : '0);
  assign hit    = (cs_sum >= ct_sum) || (wj == LEVEL_MAX);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      L_IDLE: begin
        if (cmd.start) begin
          unique case (cmd.action)
            ACT_CLEAR: state_next = L_CLR;
            ACT_ACCUM: state_next = L_ACCW;
            ACT_BUILD: state_next = L_BRD;
            ACT_REMAP: state_next = L_IDLE;
            default:   state_next = L_IDLE;
          endcase
        end
      end
      L_CLR:  if (clr_addr == LEVEL_MAX) state_next = L_IDLE;
      L_ACCW: state_next = L_IDLE;
      L_BRD:  state_next = L_BADD;
      L_BADD: state_next = (hit && wi == LEVEL_MAX) ? L_IDLE : L_BRD;
      default: state_next = L_IDLE;
    endcase
  end

  // RAM port control
  always_comb begin
    sc_we = 1'b0; sc_waddr = clr_addr; sc_wdata = '0;
    tc_we = 1'b0; tc_waddr = clr_addr; tc_wdata = '0;
    sc_re = 1'b0; sc_raddr = wj;
    tc_re = 1'b0; tc_raddr = wi;
    mp_we = 1'b0; mp_waddr = wi; mp_wdata = wj;
    mp_re = 1'b0; mp_raddr = cmd.tgt_lvl;
    unique case (state)
      L_IDLE: begin
        if (cmd.start && cmd.action == ACT_ACCUM) begin
          sc_re = 1'b1; sc_raddr = cmd.src_lvl;
          tc_re = 1'b1; tc_raddr = cmd.tgt_lvl;
        end
        if (cmd.start && cmd.action == ACT_REMAP) begin
          mp_re = 1'b1;
        end
      end
      L_CLR: begin
        sc_we = 1'b1;
        tc_we = 1'b1;
      end
      L_ACCW: begin
        sc_we = 1'b1; sc_waddr = acc_src; sc_wdata = sc_q + 1'b1;
        tc_we = 1'b1; tc_waddr = acc_tgt; tc_wdata = tc_q + 1'b1;
      end
      L_BRD: begin
        sc_re = 1'b1;
        tc_re = 1'b1;
      end
      L_BADD: begin
        mp_we = hit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= L_CLR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == L_CLR) begin
        clr_addr <= clr_addr + 1'b1;
      end else if (cmd.start && cmd.action == ACT_CLEAR) begin
        clr_addr <= '0;
      end
    end
  end

  // walk and item datapath
  always_ff @(posedge clk) begin
    if (state == L_IDLE && cmd.start) begin
      acc_src <= cmd.src_lvl;
      acc_tgt <= cmd.tgt_lvl;
      wi      <= '0;
      wj      <= '0;
      cs      <= '0;
      ct      <= '0;
      need_s  <= 1'b1;
      need_t  <= 1'b1;
    end else if (state == L_BADD) begin
      cs <= cs_sum;
      ct <= ct_sum;
      if (hit) begin
        // map this target level, advance target
        wi     <= wi + 1'b1;
        need_s <= 1'b0;
        need_t <= 1'b1;
      end else begin
        wj     <= wj + 1'b1;
        need_s <= 1'b1;
        need_t <= 1'b0;
      end
    end
  end

  hmr_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(LEVELS)) u_src_cnt (
    .clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
    .re(sc_re), .raddr(sc_raddr), .rdata(sc_q)
  );

  hmr_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(LEVELS)) u_tgt_cnt (
    .clk(clk), .we(tc_we), .waddr(tc_waddr), .wdata(tc_wdata),
    .re(tc_re), .raddr(tc_raddr), .rdata(tc_q)
  );

  hmr_ram #(.WIDTH(LVL_W), .DEPTH(LEVELS)) u_map (
    .clk(clk), .we(mp_we), .waddr(mp_waddr), .wdata(mp_wdata),
    .re(mp_re), .raddr(mp_raddr), .rdata(mp_q)
  );

  assign sts.busy  = (state != L_IDLE);
  assign sts.map_q = mp_q;

endmodule
`default_nettype wire

>>> rtl/masked_rgb_histogram_matching.sv
// Top level: masked per-channel RGB histogram matching with three channel lanes.
// Accumulate: each counted beat is a read-modify-write of the lane count RAMs; a beat
// dropped outside the mask or at full count starts no lane. Remap: the map RAM read
// is registered, then the result is loaded into the output register; no new beat is
// taken meanwhile. Clear: one count entry per cycle per lane. Build: a read, then an
// add, per step of the cumulative walk (at most 511 steps per lane). Synchronous
// reset runs the same clearing pass; no beat is taken meanwhile.
`default_nettype none
module masked_rgb_histogram_matching (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // mask_level, src_red, src_green, src_blue, tgt_red, tgt_green, tgt_blue
  input  wire logic [55:0] s_axis_tdata,
  // action
  input  wire logic [1:0]  s_axis_tuser,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_red, out_green, out_blue
  output      logic [23:0] m_axis_tdata,
  // in_region
  output      logic        m_axis_tuser
);
  import hmr_pkg::*;

  top_state_t state, state_next;

  logic [COUNT_WIDTH-1:0] total;
  logic                   accept, in_mask, acc_take, lane_start, busy_any, out_load;
  action_t                act;
  logic [LVL_W-1:0]       src_lvl [CHANNELS];
  logic [LVL_W-1:0]       tgt_lvl [CHANNELS];
  logic [LVL_W-1:0]       tgt_q   [CHANNELS];
  logic                   in_mask_q;
  lane_cmd_t              cmd     [CHANNELS];
  lane_sts_t              sts     [CHANNELS];
  logic [CHANNELS-1:0]    busy_vec;

  assign act      = action_t'(s_axis_tuser);
  assign in_mask  = (s_axis_tdata[7:0] != '0);
  assign accept   = s_axis_tvalid && s_axis_tready;
  // drop accumulate beats outside the mask or once the total count is full
  assign acc_take = in_mask && (total != '1);
  assign lane_start = accept && ((act != ACT_ACCUM) || acc_take);
  assign busy_any = |busy_vec;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE: if (accept && act == ACT_REMAP) state_next = T_ROUT;
      T_ROUT: if (!m_axis_tvalid || m_axis_tready) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      T_IDLE: s_axis_tready = !busy_any;
      T_ROUT: out_load      = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      total         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && act == ACT_CLEAR) begin
        total <= '0;
      end else if (accept && act == ACT_ACCUM && acc_take) begin
        total <= total + 1'b1;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // hold the remap pixel until the map data returns
  always_ff @(posedge clk) begin
    if (accept) begin
      in_mask_q <= in_mask;
      for (int c = 0; c < CHANNELS; c++) begin
        tgt_q[c] <= tgt_lvl[c];
      end
    end
  end

  // merge lane results into the output beat
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tuser <= in_mask_q;
      for (int c = 0; c < CHANNELS; c++) begin
        m_axis_tdata[c*LVL_W +: LVL_W] <= in_mask_q ? sts[c].map_q : tgt_q[c];
      end
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    assign src_lvl[c]     = s_axis_tdata[(c+1)*LVL_W +: LVL_W];
    assign tgt_lvl[c]     = s_axis_tdata[(c+1+CHANNELS)*LVL_W +: LVL_W];
    assign cmd[c].start   = lane_start;
    assign cmd[c].action  = act;
    assign cmd[c].src_lvl = src_lvl[c];
    assign cmd[c].tgt_lvl = tgt_lvl[c];
    assign busy_vec[c]    = sts[c].busy;

    hmr_lane u_lane (
      .clk(clk),
      .rst(rst),
      .cmd(cmd[c]),
      .sts(sts[c])
    );
  end

endmodule
`default_nettype wire

>>> rtl/hmr_checker.sv
// Port-level checks for the histogram matching top level, bound to it.
`default_nettype none
module hmr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [55:0] s_axis_tdata,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);
  import hmr_pkg::*;

  logic remap_in;
  assign remap_in = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_REMAP);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("input taken during clearing pass");

  a_remap_latency: assert property (@(posedge clk) disable iff (rst)
    remap_in && !m_axis_tvalid |=> ##1 m_axis_tvalid)
    else $error("remap result missing");

  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    remap_in && !m_axis_tvalid && (s_axis_tdata[7:0] == 8'd0) |=> ##1
      (m_axis_tdata == $past(s_axis_tdata[55:32], 2)) && !m_axis_tuser)
    else $error("pixel outside mask not passed unchanged");

endmodule

bind masked_rgb_histogram_matching hmr_checker u_hmr_checker (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking stream testbench for the masked RGB histogram matching block.
`default_nettype none
module tb_top;
  import hmr_pkg::*;

  typedef struct packed {
    action_t          act;
    logic [7:0]       mask;
    logic [2:0][7:0]  src;   // [0] red, [1] green, [2] blue
    logic [2:0][7:0]  tgt;
  } pixel_beat_t;

  typedef struct packed {
    logic [2:0][7:0] lvl;
    logic            region;
  } remap_res_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  masked_rgb_histogram_matching i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // Shadow copy of the block's histograms and level maps.
  logic [COUNT_WIDTH-1:0] src_hist [CHANNELS*LEVELS];
  logic [COUNT_WIDTH-1:0] tgt_hist [CHANNELS*LEVELS];
  logic [COUNT_WIDTH-1:0] pixel_total;
  logic [7:0]             lvl_map  [CHANNELS*LEVELS];

  pixel_beat_t pending_pixels[$];
  remap_res_t  expected_remaps[$];
  int  sender_idle_pct;
  int  receiver_stall_pct;
  int  hold_off_cycles;
  bit  drain_pause;
  bit  failed;
  bit  in_beat_taken;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Lower-bound search of the source cumulative counts per target level.
  function automatic void build_level_maps();
    logic [31:0] cum_s [LEVELS];
    logic [31:0] cum_t [LEVELS];
    logic [31:0] s, t;
    int lo, hi, mid;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      s = 0;
      t = 0;
      for (int i = 0; i < LEVELS; i++) begin
        s += src_hist[ch*LEVELS+i];
        t += tgt_hist[ch*LEVELS+i];
        cum_s[i] = s;
        cum_t[i] = t;
      end
      for (int i = 0; i < LEVELS; i++) begin
        lo = 0;
        hi = LEVELS - 1;
        while (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (cum_s[mid] < cum_t[i]) lo = mid + 1;
          else hi = mid;
        end
        lvl_map[ch*LEVELS+i] = lo[7:0];
      end
    end
  endfunction

  // Advance the shadow state by one accepted beat; queue a result for a remap beat.
  function automatic void predict_pixel(pixel_beat_t p);
    remap_res_t r;
    case (p.act)
      ACT_CLEAR: begin
        for (int i = 0; i < CHANNELS*LEVELS; i++) begin
          src_hist[i] = '0;
          tgt_hist[i] = '0;
        end
        pixel_total = '0;
      end
      ACT_ACCUM: begin
        if (p.mask != 0 && pixel_total != {COUNT_WIDTH{1'b1}}) begin
          for (int ch = 0; ch < CHANNELS; ch++) begin
            src_hist[ch*LEVELS+p.src[ch]] += 1'b1;
            tgt_hist[ch*LEVELS+p.tgt[ch]] += 1'b1;
          end
          pixel_total += 1'b1;
        end
      end
      ACT_BUILD: build_level_maps();
      default: begin
        for (int ch = 0; ch < CHANNELS; ch++)
          r.lvl[ch] = (p.mask != 0) ? lvl_map[ch*LEVELS+p.tgt[ch]] : p.tgt[ch];
        r.region = (p.mask != 0);
        expected_remaps.push_back(r);
      end
    endcase
  endfunction

  function automatic pixel_beat_t rand_pixel(action_t a);
    pixel_beat_t p;
    p.act  = a;
    p.mask = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
    for (int ch = 0; ch < CHANNELS; ch++) begin
      p.src[ch] = 8'($urandom);
      p.tgt[ch] = 8'($urandom);
    end
    return p;
  endfunction

  // Record whether the input beat was taken at the last rising edge.
  always @(posedge clk) begin
    in_beat_taken <= s_axis_tvalid && s_axis_tready;
  end

  // Driver: present beats at the falling edge, idle at random.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_beat_taken) begin
      if (pending_pixels.size() == 0 || drain_pause ||
          $urandom_range(0, 99) < sender_idle_pct) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        pixel_beat_t p;
        p = pending_pixels.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= p.act;
        s_axis_tdata  <= {p.tgt[2], p.tgt[1], p.tgt[0],
                          p.src[2], p.src[1], p.src[0], p.mask};
      end
    end
  end

  // Receiver back-pressure, with one long hold-off when the test sets it.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready   <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Monitor: predict on accepted input beats, check accepted output beats.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      predict_pixel({action_t'(s_axis_tuser), s_axis_tdata[7:0],
                     s_axis_tdata[31:8], s_axis_tdata[55:32]});
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_remaps.size() == 0) begin
        $error("unexpected result beat: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
        failed = 1'b1;
      end else begin
        remap_res_t e;
        e = expected_remaps.pop_front();
        if (m_axis_tdata[7:0] !== e.lvl[0]) begin
          $error("out_red: expected %0d, got %0d", e.lvl[0], m_axis_tdata[7:0]);
          failed = 1'b1;
        end
        if (m_axis_tdata[15:8] !== e.lvl[1]) begin
          $error("out_green: expected %0d, got %0d", e.lvl[1], m_axis_tdata[15:8]);
          failed = 1'b1;
        end
        if (m_axis_tdata[23:16] !== e.lvl[2]) begin
          $error("out_blue: expected %0d, got %0d", e.lvl[2], m_axis_tdata[23:16]);
          failed = 1'b1;
        end
        if (m_axis_tuser !== e.region) begin
          $error("in_region: expected %0d, got %0d", e.region, m_axis_tuser);
          failed = 1'b1;
        end
      end
    end
  end

  // Wait until every queued beat has been taken by the block.
  task automatic wait_sent();
    while (pending_pixels.size() != 0 || s_axis_tvalid) @(posedge clk);
  endtask

  task automatic wait_drained();
    wait_sent();
    while (expected_remaps.size() != 0) @(posedge clk);
  endtask

  // One frame: clear, accumulate n pixels, build, remap m pixels.
  task automatic queue_frame(int n, int m);
    pending_pixels.push_back(rand_pixel(ACT_CLEAR));
    for (int i = 0; i < n; i++) pending_pixels.push_back(rand_pixel(ACT_ACCUM));
    pending_pixels.push_back(rand_pixel(ACT_BUILD));
    for (int i = 0; i < m; i++) pending_pixels.push_back(rand_pixel(ACT_REMAP));
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_CLEAR;
    m_axis_tready = 1'b0;
    hold_off_cycles = 0;
    drain_pause = 1'b0;
    failed = 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    for (int i = 0; i < CHANNELS*LEVELS; i++) begin
      src_hist[i] = '0;
      tgt_hist[i] = '0;
      lvl_map[i]  = '0;
    end
    pixel_total = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: build on empty histograms maps all to zero, then extremes.
    pending_pixels.push_back('{ACT_BUILD, 8'd0, '0, '0});
    pending_pixels.push_back('{ACT_REMAP, 8'd1, '0, {8'd255, 8'd128, 8'd0}});
    pending_pixels.push_back('{ACT_REMAP, 8'd0, '1, {8'd255, 8'd0, 8'd77}});
    pending_pixels.push_back('{ACT_ACCUM, 8'd0, '1, '1});     // outside mask: ignored
    pending_pixels.push_back('{ACT_ACCUM, 8'd255, '1, '0});
    pending_pixels.push_back('{ACT_ACCUM, 8'd1, '0, '1});
    pending_pixels.push_back('{ACT_ACCUM, 8'h80, {8'h55, 8'hAA, 8'h0F}, {8'hF0, 8'h33, 8'hCC}});
    pending_pixels.push_back('{ACT_BUILD, 8'd0, '0, '0});
    pending_pixels.push_back('{ACT_REMAP, 8'd255, '1, '1});
    pending_pixels.push_back('{ACT_REMAP, 8'd2, '0, '0});
    pending_pixels.push_back('{ACT_REMAP, 8'd7, '0, {8'hCC, 8'h33, 8'hF0}});
    pending_pixels.push_back('{ACT_ACCUM, 8'd9, '0, '0});     // map kept until next build
    pending_pixels.push_back('{ACT_REMAP, 8'd9, '0, '1});
    pending_pixels.push_back('{ACT_CLEAR, 8'd0, '0, '0});
    pending_pixels.push_back('{ACT_REMAP, 8'd4, '0, '1});     // clear leaves map alone
    pending_pixels.push_back('{ACT_REMAP, 8'd0, '0, '1});
    pending_pixels.push_back('{ACT_BUILD, 8'd0, '0, '0});
    pending_pixels.push_back('{ACT_REMAP, 8'd4, '0, '1});
    wait_drained();

    // Random frames across idling phases.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 78; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 78; end
        default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
      endcase
      for (int f = 0; f < 4; f++) begin
        queue_frame($urandom_range(20, 120), $urandom_range(20, 70));
        // hold off past clear, accumulate and build so remap beats back up
        if (phase == 2 && f == 0) hold_off_cycles = 3000;
        wait_sent();
      end
      // Sender pause until all results are in.
      drain_pause = 1'b1;
      wait_drained();
      drain_pause = 1'b0;
    end
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    wait_drained();
    repeat (1300) @(posedge clk);
    if (!failed) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #(12 * 2000000);
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
rtl/hmr_pkg.sv
rtl/hmr_ram.sv
rtl/hmr_lane.sv
rtl/masked_rgb_histogram_matching.sv
rtl/hmr_checker.sv
tb/tb_top.sv
